// ----- rtl/bbr_pkg.sv -----
// bbr_pkg: shared types and constants for the 3x3 rgb box blur
// no dependencies; imported by the interfaces and by bbr_front, bbr_back and the core

package bbr_pkg;

    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int CFG_W_W       = 11;
    localparam int CFG_H_W       = 13;
    // input row counter runs up to height plus one while draining
    localparam int ROW_W         = CFG_H_W + 1;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

    // register index codes, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic emit;
        logic blur;
        logic frame_end;
    } t_op_ctl;

endpackage

// ----- rtl/bbr_ifs.sv -----
// bbr_ifs: valid/ready channel interfaces for pixels in and results out
// depends on bbr_pkg

interface bbr_in_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic            flush;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, flush, red, green, blue, input ready);
    modport sink   (input valid, flush, red, green, blue, output ready);
endinterface

interface bbr_out_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// ----- rtl/bbr_ram.sv -----
// bbr_ram: generic single write port, single read port ram with registered read
// no dependencies; a read at the address being written returns the old data

module bbr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bbr_fifo.sv -----
// bbr_fifo: small register queue between the front and the back of the blur
// no dependencies; push when full and pop when empty are ignored

module bbr_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid
);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_store[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/bbr_front.sv -----
// bbr_front: takes pixel and flush transactions, tracks the raster position
// and issues one window step per pixel, or per transaction while draining, to the queue; depends on bbr_pkg, bbr_ifs

module bbr_front #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bbr_in_if.sink                       i_pix,
    input  logic                         i_cfg_wr,
    input  logic [bbr_pkg::CFG_W_W-1:0]  i_width_cfg,
    input  logic [bbr_pkg::CFG_H_W-1:0]  i_height_cfg,
    input  logic                         i_full,
    output logic                         o_push,
    output bbr_pkg::t_pixel              o_op_pix,
    output logic [COL_W-1:0]             o_op_col,
    output bbr_pkg::t_op_ctl             o_op_ctl
);
    import bbr_pkg::*;

    localparam int XW = (COL_W > CFG_W_W) ? COL_W + 1 : CFG_W_W + 1;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_pend;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic               n_pend;

    logic [CFG_W_W-1:0] eff_w;
    logic [ROW_W-1:0]   eff_h;
    logic [XW-1:0]      col_x;
    logic [XW-1:0]      w_x;
    logic               done;
    logic               emit;
    logic               blur;
    logic               fend;
    logic               wrap;
    logic               accept;
    logic               adv;

    always_comb begin
        eff_w = i_width_cfg;
        if (i_width_cfg == '0) begin
            eff_w = CFG_W_W'(1);
        end else if (32'(i_width_cfg) > 32'(MAX_WIDTH)) begin
            eff_w = CFG_W_W'(MAX_WIDTH);
        end
    end

    assign eff_h = (i_height_cfg == '0) ? ROW_W'(1) : ROW_W'(i_height_cfg);
    assign col_x = XW'(r_col);
    assign w_x   = XW'(eff_w);

    // all rows of the frame are in: every further transaction drains
    assign done = (r_row >= eff_h);
    assign emit = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign blur = (col_x >= XW'(2)) && (col_x + XW'(1) <= w_x) &&
                  (r_row >= ROW_W'(2)) && (r_row + ROW_W'(1) <= eff_h);
    // result for the bottom right pixel leaves at column zero two rows below it
    assign fend = (r_col == '0) && (r_row == eff_h + ROW_W'(1));
    assign wrap = (col_x + XW'(1) >= w_x);

    assign i_pix.ready = !i_full && !r_pend;
    assign accept      = i_pix.valid && i_pix.ready;
    assign adv         = (accept && (done || !i_pix.flush)) || (r_pend && !i_full);

    assign o_push            = adv;
    assign o_op_col          = r_col;
    assign o_op_ctl.emit      = emit;
    assign o_op_ctl.blur      = blur;
    assign o_op_ctl.frame_end = fend;

    always_comb begin
        o_op_pix = '0;
        if (!done) begin
            o_op_pix.red   = i_pix.red;
            o_op_pix.green = i_pix.green;
            o_op_pix.blue  = i_pix.blue;
        end
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (i_cfg_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = 1'b0;
        end else begin
            if (adv) begin
                if (emit && fend) begin
                    n_col = '0;
                    n_row = '0;
                end else if (wrap) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            // single row frame: a draining transaction at column zero needs a second empty step
            if (accept && done && !emit) begin
                n_pend = 1'b1;
            end else if (r_pend && !i_full) begin
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

endmodule

// ----- rtl/bbr_back.sv -----
// bbr_back: line store, 3x3 window, channel sums and divide by nine
// depends on bbr_pkg, bbr_ifs and bbr_ram

module bbr_back #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    output logic              o_op_ready,
    input  bbr_pkg::t_pixel   i_op_pix,
    input  logic [COL_W-1:0]  i_op_col,
    input  bbr_pkg::t_op_ctl  i_op_ctl,
    bbr_out_if.source         o_pix
);
    import bbr_pkg::*;

    localparam int SUM_W  = CH_W + 4;
    localparam int PROD_W = 2 * SUM_W + 1;
    // 2^16 / 9 rounded up, exact for sums up to nine full-scale values
    localparam logic [SUM_W:0] DIV9_MUL = (SUM_W + 1)'(7282);

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV9_MUL);
        return p[16 +: CH_W];
    endfunction

    logic               en;

    // stage 1: line store data back
    logic               r_s1_v;
    t_pixel             r_s1_pix;
    logic [COL_W-1:0]   r_s1_col;
    t_op_ctl            r_s1_ctl;
    logic               r_fwd;
    t_pixel             r_fwd_top;
    t_pixel             r_fwd_mid;
    logic [2*PIX_W-1:0] ram_q;
    t_pixel             s1_top;
    t_pixel             s1_mid;

    t_pixel             r_win [9];
    t_pixel             n_win [9];

    // stage 2: sums
    logic               r_s2_v;
    t_op_ctl            r_s2_ctl;
    t_pixel             r_s2_ctr;
    logic [SUM_W-1:0]   r_s2_sum [3];
    logic [SUM_W-1:0]   sum_c [3];
    logic [SUM_W-1:0]   row_s [3][3];

    // output register
    logic               r_out_v;
    t_pixel             r_out_pix;
    logic               r_out_fend;

    assign en         = !r_out_v || o_pix.ready;
    assign o_op_ready = en;

    bbr_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (en && r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata ({s1_mid, r_s1_pix}),
        .i_re    (en && i_op_valid),
        .i_raddr (i_op_col),
        .o_rdata (ram_q)
    );

    // same column read while it was being written: take the written data
    assign s1_top = r_fwd ? r_fwd_top : t_pixel'(ram_q[2*PIX_W-1:PIX_W]);
    assign s1_mid = r_fwd ? r_fwd_mid : t_pixel'(ram_q[PIX_W-1:0]);

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = s1_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = s1_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            row_s[0][k] = SUM_W'(n_win[3*k].red) + SUM_W'(n_win[3*k+1].red) +
                          SUM_W'(n_win[3*k+2].red);
            row_s[1][k] = SUM_W'(n_win[3*k].green) + SUM_W'(n_win[3*k+1].green) +
                          SUM_W'(n_win[3*k+2].green);
            row_s[2][k] = SUM_W'(n_win[3*k].blue) + SUM_W'(n_win[3*k+1].blue) +
                          SUM_W'(n_win[3*k+2].blue);
        end
        for (int c = 0; c < 3; c++) begin
            sum_c[c] = row_s[c][0] + row_s[c][1] + row_s[c][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd   <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (en) begin
            r_s1_v  <= i_op_valid;
            r_fwd   <= i_op_valid && r_s1_v && (i_op_col == r_s1_col);
            r_s2_v  <= r_s1_v && r_s1_ctl.emit;
            r_out_v <= r_s2_v;
            if (r_s1_v) begin
                for (int k = 0; k < 9; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix  <= i_op_pix;
            r_s1_col  <= i_op_col;
            r_s1_ctl  <= i_op_ctl;
            r_fwd_top <= s1_mid;
            r_fwd_mid <= r_s1_pix;
            r_s2_ctl  <= r_s1_ctl;
            r_s2_ctr  <= n_win[4];
            for (int c = 0; c < 3; c++) begin
                r_s2_sum[c] <= sum_c[c];
            end
            r_out_fend <= r_s2_ctl.frame_end;
            if (r_s2_ctl.blur) begin
                r_out_pix.red   <= div9(r_s2_sum[0]);
                r_out_pix.green <= div9(r_s2_sum[1]);
                r_out_pix.blue  <= div9(r_s2_sum[2]);
            end else begin
                r_out_pix <= r_s2_ctr;
            end
        end
    end

    assign o_pix.valid     = r_out_v;
    assign o_pix.out_red   = r_out_pix.red;
    assign o_pix.out_green = r_out_pix.green;
    assign o_pix.out_blue  = r_out_pix.blue;
    assign o_pix.frame_end = r_out_fend;

endmodule

// ----- rtl/box_blur_3x3_rgb_core.sv -----
// box_blur_3x3_rgb_core: top level of the streaming 3x3 rgb box blur
// depends on bbr_pkg, bbr_ifs, bbr_front, bbr_fifo, bbr_back, bbr_ram
//
//  channel  | dir | handshake              | payload
//  i_pix    | in  | valid/ready            | flush, red, green, blue
//  o_pix    | out | valid/ready            | out_red, out_green, out_blue, frame_end
//  apb      | in  | psel/penable, pready=1 | image_width @0x0, image_height @0x4
//
// one transaction per cycle in and out while nothing stalls; a draining transaction
// in a one-row frame at column zero takes a second, empty step in the front
// a result leaves width + 1 transactions after its pixel, then passes through
// the queue, line store read, sum and divide stages
// synchronous active-low reset clears positions, pipeline and registers to
// 640 x 480; the line store is not cleared
// a stalled output freezes the back stages; input ready drops when the four-entry
// queue is full or the front holds a pending empty step

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbr_pkg::APB_AW-1:0]  paddr,
    input  logic [bbr_pkg::APB_DW-1:0]  pwdata,
    output logic [bbr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    bbr_in_if.sink                      i_pix,
    bbr_out_if.source                   o_pix
);
    import bbr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int OP_W  = $bits(t_op_ctl) + COL_W + PIX_W;

    logic [CFG_W_W-1:0] r_width_cfg;
    logic [CFG_H_W-1:0] r_height_cfg;
    logic               cfg_wr;

    logic               push;
    logic               full;
    t_pixel             f_pix;
    logic [COL_W-1:0]   f_col;
    t_op_ctl            f_ctl;
    logic [OP_W-1:0]    q_data;
    logic               q_valid;
    logic               q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= WIDTH_RESET;
            r_height_cfg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IDX_HEIGHT) begin
                r_height_cfg <= pwdata[CFG_H_W-1:0];
            end else begin
                r_width_cfg <= pwdata[CFG_W_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_IDX_WIDTH) ? APB_DW'(r_width_cfg)
                                                : APB_DW'(r_height_cfg);

    bbr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_cfg_wr     (cfg_wr),
        .i_width_cfg  (r_width_cfg),
        .i_height_cfg (r_height_cfg),
        .i_full       (full),
        .o_push       (push),
        .o_op_pix     (f_pix),
        .o_op_col     (f_col),
        .o_op_ctl     (f_ctl)
    );

    bbr_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_col, f_pix}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid)
    );

    bbr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .o_op_ready (q_pop),
        .i_op_pix   (t_pixel'(q_data[PIX_W-1:0])),
        .i_op_col   (q_data[PIX_W +: COL_W]),
        .i_op_ctl   (t_op_ctl'(q_data[OP_W-1 -: $bits(t_op_ctl)])),
        .o_pix      (o_pix)
    );

endmodule

// ----- bench/box_blur_3x3_rgb_checker.sv -----
// box_blur_3x3_rgb_checker: watches the pixel, result and register ports of the blur core,
// predicts each result from its own copy of line stores and window, and counts mismatches
// depends on bbr_pkg and bbr_ifs
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bbr_pkg::APB_AW-1:0] paddr,
    input  logic [bbr_pkg::APB_DW-1:0] pwdata,
    input  logic [bbr_pkg::APB_DW-1:0] prdata,
    input  logic                       pready,
    bbr_in_if                          i_pix,
    bbr_out_if                         o_pix,
    output int                         o_fail_count,
    output int                         o_pending
);
    import bbr_pkg::*;

    localparam int WINDOW_SIZE = 9;

    typedef struct packed {
        t_pixel pix;
        logic   frame_end;
    } t_blur_result;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    t_pixel             row_two_back[MAX_WIDTH];
    t_pixel             row_one_back[MAX_WIDTH];
    t_pixel             win_px[WINDOW_SIZE];
    int unsigned        in_col;
    int unsigned        in_row;
    int unsigned        out_idx;
    t_blur_result       blur_expected[$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [CH_W-1:0] got,
                               input logic [CH_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic int unsigned eff_width();
        int unsigned w;
        w = (width_reg == '0) ? 1 : width_reg;
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    function automatic t_pixel window_mean();
        int unsigned sr, sg, sb;
        int          k;
        t_pixel      m;
        sr = 0;
        sg = 0;
        sb = 0;
        for (k = 0; k < WINDOW_SIZE; k++) begin
            sr += win_px[k].red;
            sg += win_px[k].green;
            sb += win_px[k].blue;
        end
        m.red   = CH_W'(sr / WINDOW_SIZE);
        m.green = CH_W'(sg / WINDOW_SIZE);
        m.blue  = CH_W'(sb / WINDOW_SIZE);
        return m;
    endfunction

    // one raster step, real pixel or empty; returns 1 when a result falls out
    function automatic bit shift_in(input t_pixel px, input int unsigned w, h,
                                    output t_pixel res);
        int unsigned ic, ir, col, cr, cc;
        int          k;
        t_pixel      last_px, top_px, mid_px;
        bit          emit;
        ic      = in_col;
        ir      = in_row;
        col     = (ic < MAX_WIDTH) ? ic : 0;
        last_px = row_two_back[w - 1];
        top_px  = row_two_back[col];
        mid_px  = row_one_back[col];
        emit    = (ir >= 2) || (ir == 1 && ic >= 1);
        for (k = 0; k < 3; k++) begin
            win_px[3 * k]     = win_px[3 * k + 1];
            win_px[3 * k + 1] = win_px[3 * k + 2];
        end
        win_px[2]         = top_px;
        win_px[5]         = mid_px;
        win_px[8]         = px;
        row_two_back[col] = mid_px;
        row_one_back[col] = px;
        in_col = ic + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = ir + 1;
        end
        res = '0;
        if (!emit)
            return 1'b0;
        // at column zero the pending result is the last pixel of the row two above
        if (ic == 0) begin
            res = last_px;
        end else begin
            cr  = ir - 1;
            cc  = ic - 1;
            res = win_px[4];
            if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w)
                res = window_mean();
        end
        return 1'b1;
    endfunction

    function automatic bit predict_item(input logic fl, input t_pixel px,
                                        output t_blur_result r);
        int unsigned w, h, total;
        t_pixel      res;
        bit          got;
        w     = eff_width();
        h     = eff_height();
        total = w * h;
        r     = '0;
        res   = '0;
        if (in_row < h) begin
            // early flush is dropped
            if (fl)
                return 1'b0;
            got = shift_in(px, w, h, res);
        end else begin
            // draining: anything pushes one result, a one-row frame may need two steps
            got = shift_in('0, w, h, res);
            if (!got)
                got = shift_in('0, w, h, res);
        end
        if (!got)
            return 1'b0;
        r.pix       = res;
        r.frame_end = (out_idx + 1 >= total);
        out_idx++;
        if (out_idx >= total) begin
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_blur_result      made;
        t_blur_result      want;
        logic [APB_DW-1:0] reg_val;
        int                k;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (k = 0; k < MAX_WIDTH; k++) begin
                row_two_back[k] = '0;
                row_one_back[k] = '0;
            end
            for (k = 0; k < WINDOW_SIZE; k++)
                win_px[k] = '0;
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
            blur_expected.delete();
            o_pending = 0;
        end else begin
            if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
                if (pwrite) begin
                    if (paddr[2] == REG_IDX_WIDTH)
                        width_reg = pwdata[CFG_W_W-1:0];
                    else
                        height_reg = pwdata[CFG_H_W-1:0];
                    // a register write starts the frame afresh
                    in_col  = 0;
                    in_row  = 0;
                    out_idx = 0;
                end else begin
                    reg_val = (paddr[2] == REG_IDX_WIDTH) ? APB_DW'(width_reg)
                                                          : APB_DW'(height_reg);
                    if (prdata !== reg_val)
                        report_mismatch($sformatf("register read at %0h got %0h expected %0h",
                                                  paddr, prdata, reg_val));
                end
            end
            if (o_pix.valid === 1'b1 && o_pix.ready === 1'b1) begin
                if (blur_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0h %0h %0h with nothing outstanding",
                                              o_pix.out_red, o_pix.out_green, o_pix.out_blue));
                end else begin
                    want = blur_expected.pop_front();
                    check_field("red", o_pix.out_red, want.pix.red);
                    check_field("green", o_pix.out_green, want.pix.green);
                    check_field("blue", o_pix.out_blue, want.pix.blue);
                    check_field("frame_end", CH_W'(o_pix.frame_end), CH_W'(want.frame_end));
                end
            end
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1) begin
                if (predict_item(i_pix.flush, {i_pix.red, i_pix.green, i_pix.blue}, made))
                    blur_expected.push_back(made);
            end
            o_pending = blur_expected.size();
        end
    end

endmodule

// ----- bench/box_blur_3x3_rgb_core_tb.sv -----
// box_blur_3x3_rgb_core_tb: drives frames of pixels and register writes into the blur core
// and reports the verdict; prediction and comparison sit in box_blur_3x3_rgb_checker
// depends on bbr_pkg, bbr_ifs, box_blur_3x3_rgb_core and box_blur_3x3_rgb_checker
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_tb;
    import bbr_pkg::*;

    localparam int ITEM_GOAL     = 700;
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_CYCLES  = 64;

    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } t_idle_phase;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              sink_ready = 1'b0;

    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                fail_count;
    int                pending;
    int unsigned       items_sent = 0;
    int unsigned       frame_w;
    int unsigned       frame_h;

    bbr_in_if  pix_in ();
    bbr_out_if pix_out ();

    assign pix_out.ready = sink_ready;

    box_blur_3x3_rgb_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    box_blur_3x3_rgb_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_pix        (pix_in),
        .o_pix        (pix_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(negedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.red   = CH_W'($urandom_range(255));
        p.green = CH_W'($urandom_range(255));
        p.blue  = CH_W'($urandom_range(255));
        return p;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic fl, input t_pixel px);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.flush <= fl;
        pix_in.red   <= px.red;
        pix_in.green <= px.green;
        pix_in.blue  <= px.blue;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_drained(input int extra);
        pix_in.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    // write a register, then read it back
    task automatic apb_access(input logic idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [APB_DW-1:0] w_val, input logic [APB_DW-1:0] h_val);
        wait_drained(SETTLE_CYCLES);
        apb_access(REG_IDX_WIDTH, w_val);
        apb_access(REG_IDX_HEIGHT, h_val);
        frame_w = (w_val[CFG_W_W-1:0] == '0) ? 1 : w_val[CFG_W_W-1:0];
        if (frame_w > MAX_WIDTH_DEF)
            frame_w = MAX_WIDTH_DEF;
        frame_h = (h_val[CFG_H_W-1:0] == '0) ? 1 : h_val[CFG_H_W-1:0];
    endtask

    // px_limit below w * h leaves the frame unfinished
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned px_limit, input bit pause);
        int unsigned total, stop_at, pause_at, n_px, n_flush;
        total    = w * h;
        stop_at  = (px_limit < total) ? px_limit : total;
        pause_at = pause ? $urandom_range(total - 1) : total;
        for (n_px = 0; n_px < stop_at; n_px++) begin
            if (n_px == pause_at)
                wait_drained(0);
            // stray flush mid-frame, dropped by the block
            if ($urandom_range(19) == 0)
                send_item(1'b1, rand_pixel());
            send_item(1'b0, rand_pixel());
            items_sent++;
        end
        if (stop_at < total)
            return;
        n_flush = (total < w + 1) ? total : w + 1;
        repeat (n_flush) begin
            // a surplus pixel drains just like a flush
            send_item($urandom_range(4) != 0, rand_pixel());
            items_sent++;
        end
    endtask

    initial begin
        int unsigned  k;
        int unsigned  rand_base;
        int unsigned  frame_no;
        int unsigned  total;
        int unsigned  px_limit;
        logic [31:0]  w_val;
        logic [31:0]  h_val;
        bit           need_cfg;
        t_idle_phase  phase;

        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pix_in.valid = 1'b0;
        pix_in.flush = 1'b0;
        pix_in.red   = '0;
        pix_in.green = '0;
        pix_in.blue  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frame with an interior pixel, extreme channel values
        set_frame(3, 3);
        for (k = 0; k < 9; k++) begin
            if (k == 3)
                send_item(1'b1, '0);
            if (k == 0)
                send_item(1'b0, '0);
            else if (k == 4)
                send_item(1'b0, {8'hFF, 8'h00, 8'hFF});
            else
                send_item(1'b0, '1);
        end
        send_item(1'b0, {8'h5A, 8'hA5, 8'h3C});
        repeat (3) send_item(1'b1, '1);
        items_sent += 14;
        // flush at the start of the next frame is dropped
        send_item(1'b1, '0);

        // zero sizes count as one, then one-row and one-column frames
        set_frame(0, 0);
        run_frame(frame_w, frame_h, frame_w * frame_h, 1'b0);
        set_frame(2, 1);
        run_frame(frame_w, frame_h, frame_w * frame_h, 1'b0);
        set_frame(1, 3);
        run_frame(frame_w, frame_h, frame_w * frame_h, 1'b0);

        // widest and tallest settings, frames cut short
        set_frame('1, '1);
        run_frame(frame_w, frame_h, 20, 1'b0);
        set_frame(3, 4096);
        run_frame(frame_w, frame_h, 40, 1'b0);

        rand_base = items_sent;
        frame_no  = 0;
        need_cfg  = 1'b1;
        while (items_sent - rand_base < ITEM_GOAL) begin
            phase = t_idle_phase'((items_sent - rand_base) * 4 / ITEM_GOAL);
            case (phase)
                PH_STEADY: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                PH_SRC_IDLE: begin
                    src_idle_pct   = 79;
                    sink_stall_pct = 0;
                end
                PH_SINK_STALL: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 79;
                end
                default: begin
                    src_idle_pct   = 11;
                    sink_stall_pct = 11;
                end
            endcase
            if (need_cfg || $urandom_range(1) == 0) begin
                w_val = ($urandom_range(7) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
                h_val = $urandom_range(6, 1);
                if ($urandom_range(29) == 0)
                    w_val = 0;
                if ($urandom_range(29) == 0)
                    h_val = 0;
                set_frame(w_val, h_val);
            end
            total    = frame_w * frame_h;
            need_cfg = ($urandom_range(9) == 0);
            px_limit = need_cfg ? $urandom_range(total - 1) : total;
            run_frame(frame_w, frame_h, px_limit, (frame_no % 6) == 0);
            frame_no++;
        end

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bbr_pkg.sv
rtl/bbr_ifs.sv
rtl/bbr_ram.sv
rtl/bbr_fifo.sv
rtl/bbr_front.sv
rtl/bbr_back.sv
rtl/box_blur_3x3_rgb_core.sv
bench/box_blur_3x3_rgb_checker.sv
bench/box_blur_3x3_rgb_core_tb.sv
